// File: sv/tct_pkg.sv
`timescale 1ns / 1ps

package tct_pkg;

   localparam int REQ_BITS = 16;
   localparam int RSP_BITS = 32;

   localparam logic [2:0] CMD_CONTROL = 3'd0;
   localparam logic [2:0] CMD_WRITE   = 3'd1;
   localparam logic [2:0] CMD_READ    = 3'd2;
   localparam logic [2:0] CMD_GATE    = 3'd3;
   localparam logic [2:0] CMD_TICK    = 3'd4;
   localparam logic [2:0] CMD_EDGE    = 3'd5;

   localparam logic [1:0] ORD_LATCH = 2'd0;
   localparam logic [1:0] ORD_LOW   = 2'd1;
   localparam logic [1:0] ORD_HIGH  = 2'd2;
   localparam logic [1:0] ORD_BOTH  = 2'd3;

   localparam logic [2:0] MODE_ONESHOT = 3'd0;
   localparam logic [2:0] MODE_RATE    = 3'd2;
   localparam logic [2:0] MODE_SQUARE  = 3'd3;
   localparam logic [2:0] MODE_GATED   = 3'd4;
   localparam logic [2:0] MODE_LAST    = 3'd5;

   localparam logic [1:0] CHAN_LIMIT = 2'd3;

   typedef struct packed {
      logic [1:0] order;
      logic       latch;
      logic [2:0] mode;
      logic       bcd;
      logic       hi_next;
      logic       load_pend;
      logic       gate;
      logic       out_st;
      logic       edge_pend;
      logic       reloaded;
   } ctrl_type;

   localparam ctrl_type CTRL_RESET = '{order: ORD_LOW, mode: MODE_ONESHOT, default: '0};

   typedef struct packed {
      logic [15:0] reload_now;
      logic [2:0]  mode_now;
      logic        gate_now;
      logic        updated_flag;
      logic        edge_flag;
      logic        out_level;
      logic [7:0]  read_data;
   } rsp_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       out_level;
      logic       edge_flag;
   } step_out_type;

endpackage

// File: sv/tct_chan_logic.sv
`timescale 1ns / 1ps

module tct_chan_logic #(
   parameter int COUNT_BITS = 16
) (
   input  logic [2:0]            cmd,
   input  logic [7:0]            data,
   input  logic                  gate_level,
   input  tct_pkg::ctrl_type     st_in,
   input  logic [COUNT_BITS-1:0] cnt_in,
   input  logic [COUNT_BITS-1:0] rld_in,
   input  logic [COUNT_BITS-1:0] lat_in,
   output tct_pkg::ctrl_type     st_out,
   output logic [COUNT_BITS-1:0] cnt_out,
   output logic [COUNT_BITS-1:0] rld_out,
   output logic [COUNT_BITS-1:0] lat_out,
   output tct_pkg::step_out_type res
);
   import tct_pkg::*;

   always_comb begin
      ctrl_type              st;
      logic [COUNT_BITS-1:0] cnt;
      logic [COUNT_BITS-1:0] rld;
      logic [COUNT_BITS-1:0] lat;
      logic [15:0]           wide;
      logic [2:0]            m;
      logic                  hi_sel;
      logic                  prev;
      logic [7:0]            rd;
      logic                  lvl;
      logic                  edge_o;

      st     = st_in;
      cnt    = cnt_in;
      rld    = rld_in;
      lat    = lat_in;
      wide   = '0;
      m      = '0;
      hi_sel = 1'b0;
      prev   = 1'b0;
      rd     = '0;

      case (cmd)
         CMD_CONTROL: begin
            if (data[5:4] == ORD_LATCH) begin
               st.latch = 1'b1;
               lat      = cnt;
            end else begin
               st.latch = 1'b0;
               st.order = data[5:4];
               if (data[5:4] == ORD_BOTH) st.hi_next = 1'b0;
               m = data[3:1];
               if (m > MODE_LAST) m = {1'b0, m[1:0]};
               st.mode      = m;
               st.edge_pend = !st.out_st && (m != MODE_ONESHOT);
               st.out_st    = (m != MODE_ONESHOT);
               if (m == MODE_SQUARE) begin
                  rld         = '0;
                  cnt         = '0;
                  st.reloaded = 1'b1;
               end
               st.bcd = data[0];
            end
         end
         CMD_WRITE: begin
            if (st.order == ORD_BOTH) begin
               hi_sel       = st.hi_next;
               st.load_pend = st.hi_next;
               st.hi_next   = !st.hi_next;
            end else begin
               hi_sel       = (st.order == ORD_HIGH);
               st.load_pend = 1'b1;
            end
            wide = 16'(rld);
            if (hi_sel) wide[15:8] = data;
            else        wide[7:0]  = data;
            rld = wide[COUNT_BITS-1:0];
            if (st.mode == MODE_ONESHOT) begin
               st.out_st    = 1'b0;
               st.edge_pend = 1'b0;
            end
         end
         CMD_READ: begin
            if (st.order == ORD_BOTH) begin
               hi_sel     = st.hi_next;
               st.hi_next = !st.hi_next;
            end else begin
               hi_sel = (st.order == ORD_HIGH);
            end
            wide = 16'(cnt);
            rd   = hi_sel ? wide[15:8] : wide[7:0];
         end
         CMD_GATE: begin
            if (!st.gate && gate_level) begin
               if (st.mode == MODE_RATE) cnt = rld;
            end else if (!gate_level) begin
               if (st.mode == MODE_RATE || st.mode == MODE_SQUARE) begin
                  st.edge_pend = !st.out_st;
                  st.out_st    = 1'b1;
               end
            end
            st.gate = gate_level;
         end
         default: begin
         end
      endcase

      lvl    = st.out_st;
      edge_o = st.edge_pend;

      if (cmd == CMD_TICK) begin
         if (st.load_pend) begin
            cnt          = rld;
            st.load_pend = 1'b0;
            st.reloaded  = 1'b1;
            lvl          = 1'b0;
         end else begin
            st.reloaded = 1'b0;
            if (cnt == '0) begin
               st.edge_pend = 1'b0;
            end else begin
               prev = st.out_st;
               case (st.mode)
                  MODE_ONESHOT: begin
                     if (!st.gate) begin
                        st.out_st = 1'b0;
                     end else begin
                        cnt       = cnt - COUNT_BITS'(1);
                        st.out_st = (cnt == '0);
                     end
                  end
                  MODE_RATE: begin
                     if (st.gate) begin
                        cnt = cnt - COUNT_BITS'(1);
                        if (cnt == '0) begin
                           st.out_st    = 1'b1;
                           st.load_pend = 1'b1;
                        end else begin
                           st.out_st = 1'b0;
                        end
                     end
                  end
                  MODE_SQUARE: begin
                     if (st.gate) begin
                        cnt = cnt - COUNT_BITS'(1);
                        if (cnt >= (rld >> 1)) begin
                           st.out_st = 1'b1;
                        end else begin
                           st.out_st = 1'b0;
                           if (cnt == '0) st.load_pend = 1'b1;
                        end
                     end
                  end
                  MODE_GATED: begin
                     if (!st.gate) st.out_st = 1'b0;
                     else          cnt = cnt - COUNT_BITS'(1);
                  end
                  default: begin
                     cnt = cnt - COUNT_BITS'(1);
                  end
               endcase
               st.edge_pend = st.out_st && !prev;
            end
            lvl = st.out_st;
         end
         edge_o = st.edge_pend;
      end else if (cmd == CMD_EDGE) begin
         st.edge_pend = 1'b0;
      end

      st_out        = st;
      cnt_out       = cnt;
      rld_out       = rld;
      lat_out       = lat;
      res.read_data = rd;
      res.out_level = lvl;
      res.edge_flag = edge_o;
   end

endmodule

// File: sv/three_channel_interval_timer.sv
`timescale 1ns / 1ps

// Three-channel programmable interval timer with 16-bit down counters. Each request
// transaction is a control write, reload byte write, count byte read, gate change,
// count tick or edge query, and produces exactly one response transaction carrying
// the channel's status. Requests are registered on entry and resolved by a single shared
// channel update against the addressed channel's registers; one request is taken every
// clock unless the response side stalls, and the result passes from the request register
// into the response register. Channel 3, and any channel at or above NUM_CHANNELS, is
// ignored and answers all zeros, as do command codes 6 and 7. Reads return the live count;
// the latched count is captured but not returned. The BCD bit is stored only.

module three_channel_interval_timer #(
   parameter int NUM_CHANNELS = 3,
   parameter int COUNT_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [2:0] cmd, [4:3] channel, [12:5] data, [13] gate_level, [15:14] zero
   input  logic [tct_pkg::REQ_BITS-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] read_data, [8] out_level, [9] edge_flag, [10] updated_flag, [11] gate_now,
   // [14:12] mode_now, [30:15] reload_now, [31] zero
   output logic [tct_pkg::RSP_BITS-1:0]  rsp_tdata
);
   import tct_pkg::*;

   localparam int IDX_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic                  in_valid_ff, in_valid_in;
   logic [2:0]            in_cmd_ff;
   logic [1:0]            in_ch_ff;
   logic [7:0]            in_data_ff;
   logic                  in_gate_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   ctrl_type              ctrl_ff [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] cnt_ff  [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] rld_ff  [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] lat_ff  [NUM_CHANNELS];

   logic                  req_fire, advance, fire, chan_ok;
   logic [1:0]            chan_sel;
   logic [IDX_BITS-1:0]   chan_idx;
   ctrl_type              st_new;
   logic [COUNT_BITS-1:0] cnt_new, rld_new, lat_new;
   step_out_type          step_res;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign fire       = in_valid_ff && advance;

   assign chan_sel = (in_cmd_ff == CMD_CONTROL) ? in_data_ff[7:6] : in_ch_ff;
   assign chan_ok  = (in_cmd_ff <= CMD_EDGE) && (chan_sel < CHAN_LIMIT)
                     && (32'(chan_sel) < NUM_CHANNELS);
   assign chan_idx = chan_ok ? chan_sel[IDX_BITS-1:0] : '0;

   tct_chan_logic #(
      .COUNT_BITS (COUNT_BITS)
   ) u_chan_logic (
      .cmd        (in_cmd_ff),
      .data       (in_data_ff),
      .gate_level (in_gate_ff),
      .st_in      (ctrl_ff[chan_idx]),
      .cnt_in     (cnt_ff[chan_idx]),
      .rld_in     (rld_ff[chan_idx]),
      .lat_in     (lat_ff[chan_idx]),
      .st_out     (st_new),
      .cnt_out    (cnt_new),
      .rld_out    (rld_new),
      .lat_out    (lat_new),
      .res        (step_res)
   );

   always_comb begin
      rsp_in = '0;
      if (chan_ok) begin
         rsp_in.read_data    = step_res.read_data;
         rsp_in.out_level    = step_res.out_level;
         rsp_in.edge_flag    = step_res.edge_flag;
         rsp_in.updated_flag = st_new.reloaded;
         rsp_in.gate_now     = st_new.gate;
         rsp_in.mode_now     = st_new.mode;
         rsp_in.reload_now   = 16'(rld_new);
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)  in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (fire)            rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff  <= req_tdata[2:0];
         in_ch_ff   <= req_tdata[4:3];
         in_data_ff <= req_tdata[12:5];
         in_gate_ff <= req_tdata[13];
      end
      if (fire) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            ctrl_ff[i] <= CTRL_RESET;
            cnt_ff[i]  <= '0;
            rld_ff[i]  <= '0;
            lat_ff[i]  <= '0;
         end
      end else if (fire && chan_ok) begin
         ctrl_ff[chan_idx] <= st_new;
         cnt_ff[chan_idx]  <= cnt_new;
         rld_ff[chan_idx]  <= rld_new;
         lat_ff[chan_idx]  <= lat_new;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   a_fire_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("resolved transaction did not reach the response register");

   a_in_holds : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)
                                     && $stable(in_cmd_ff)))
      else $error("stalled request register changed");

   a_ignored_zero : assert property (@(posedge clock) disable iff (reset)
      (fire && !chan_ok) |=> (rsp_ff == '0))
      else $error("ignored transaction gave a non-zero response");

   a_order_kept : assert property (@(posedge clock) disable iff (reset)
      ctrl_ff[0].order != ORD_LATCH)
      else $error("latch command overwrote the read/load order");

endmodule
